[design/bspl_pkg.sv]
// ----------------------------------------------------------------------------
// bspl_pkg
// Shared types, constants and fixed-point helpers of the B-spline evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package bspl_pkg;

  localparam int MAX_KNOTS  = 32;
  localparam int MAX_DEGREE = 3;
  localparam int SLOT_W     = $clog2(MAX_KNOTS);
  localparam int CNT_W      = $clog2(MAX_KNOTS + 1);
  localparam int ORD_W      = 3;
  localparam int ACC_W      = 40;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  localparam logic CFG_DEGREE     = 1'b0;
  localparam logic CFG_KNOT_COUNT = 1'b1;

  typedef enum logic [1:0] {
    KIND_KNOT = 2'd0,
    KIND_CTRL = 2'd1,
    KIND_EVAL = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [SLOT_W-1:0]  slot;
    logic signed [31:0] knot_value;
    logic signed [31:0] ctrl_x;
    logic signed [31:0] ctrl_y;
    logic signed [31:0] param_u;
    logic               last_param;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] m;
    logic [ORD_W-1:0] kk;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] curve_x;
    logic signed [31:0] curve_y;
    logic               ok;
  } result_t;

  // Drop 30 fraction bits of a product, rounding toward zero.
  function automatic logic signed [33:0] trunc_q30(input logic signed [63:0] p);
    logic signed [63:0] b;
    b = p + (p[63] ? 64'sd1073741823 : 64'sd0);
    return b[63:30];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(S32_MAX)) return S32_MAX;
    if (v < ACC_W'(S32_MIN)) return S32_MIN;
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

[design/bspl_div.sv]
// ----------------------------------------------------------------------------
// bspl_div
// Iterative Q2.30 ratio unit: (num * 2^30) / den, truncated, saturated,
// zero for a zero divisor. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bspl_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [32:0] num,
  input  wire logic signed [32:0] den,
  output logic                    done,
  output logic signed [31:0]      quo
);
  import bspl_pkg::*;

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_RUN  = 4'b0010,
    D_FIN  = 4'b0100,
    D_DONE = 4'b1000
  } dstate_t;

  dstate_t     state;
  logic [31:0] rem;
  logic [32:0] sh;
  logic [32:0] qm;
  logic [31:0] dv;
  logic [5:0]  cnt;
  logic        neg;
  logic [32:0] an_w;
  logic [32:0] ad_w;
  logic [32:0] r2;

  always_comb begin
    an_w = num[32] ? 33'(-num) : 33'(num);
    ad_w = den[32] ? 33'(-den) : 33'(den);
    r2   = {rem, sh[32]};
  end

  assign done = (state == D_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      case (state)
        // a new ratio may start in the cycle the previous one is reported
        D_IDLE, D_DONE: begin
          state <= D_IDLE;
          if (start) begin
            neg <= num[32] ^ den[32];
            dv  <= ad_w[31:0];
            if (den == 33'sd0) begin
              quo   <= 32'sd0;
              state <= D_DONE;
            end else if ({3'b000, an_w[31:0]} >= {ad_w[31:0], 3'b000}) begin
              // quotient does not fit: clamp by sign
              quo   <= (num[32] ^ den[32]) ? S32_MIN : S32_MAX;
              state <= D_DONE;
            end else begin
              rem   <= {3'b000, an_w[31:3]};
              sh    <= {an_w[2:0], 30'd0};
              qm    <= '0;
              cnt   <= 6'd33;
              state <= D_RUN;
            end
          end
        end
        D_RUN: begin
          if (r2 >= {1'b0, dv}) begin
            rem <= 32'(r2 - {1'b0, dv});
            qm  <= {qm[31:0], 1'b1};
          end else begin
            rem <= r2[31:0];
            qm  <= {qm[31:0], 1'b0};
          end
          sh  <= {sh[31:0], 1'b0};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          if (neg) begin
            quo <= (qm > 33'h0_8000_0000) ? S32_MIN : 32'(-qm[31:0]);
          end else begin
            quo <= (qm > 33'h0_7FFF_FFFF) ? S32_MAX : qm[31:0];
          end
          state <= D_DONE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/bspl_eval.sv]
// ----------------------------------------------------------------------------
// bspl_eval
// Table memories and the sequencer that runs the Cox-de Boor recursion in
// place over a weight memory, then sums the weighted control points.
// ----------------------------------------------------------------------------
`default_nettype none

module bspl_eval (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire bspl_pkg::cfg_t   cfg,
  input  wire logic             in_valid,
  input  wire bspl_pkg::item_t  in_item,
  output logic                  in_ready,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output bspl_pkg::result_t     res
);
  import bspl_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_Z_RD0 = 19'h00002,
    S_Z_RD1 = 19'h00004,
    S_Z_WR  = 19'h00008,
    S_L_RD0 = 19'h00010,
    S_L_RD1 = 19'h00020,
    S_L_RD2 = 19'h00040,
    S_L_RD3 = 19'h00080,
    S_L_RD4 = 19'h00100,
    S_L_DV1 = 19'h00200,
    S_L_DV2 = 19'h00400,
    S_L_MU1 = 19'h00800,
    S_L_MU2 = 19'h01000,
    S_L_MU3 = 19'h02000,
    S_S_RD  = 19'h04000,
    S_S_MX  = 19'h08000,
    S_S_MY  = 19'h10000,
    S_S_AY  = 19'h20000,
    S_DONE  = 19'h40000
  } estate_t;

  estate_t state;

  logic signed [31:0] kmem [MAX_KNOTS];
  logic [63:0]        cmem [MAX_KNOTS];
  logic signed [31:0] wmem [MAX_KNOTS];

  logic signed [31:0] kq;
  logic signed [31:0] wq;
  logic [63:0]        cq;
  logic [SLOT_W-1:0]  k_raddr;
  logic [SLOT_W-1:0]  w_raddr;

  logic [SLOT_W-1:0]  i;
  logic [ORD_W-1:0]   k;
  logic [CNT_W-1:0]   m_r;
  logic [ORD_W-1:0]   kk_r;
  logic signed [31:0] u;
  logic               last;
  logic               okr;
  logic signed [31:0] t0, t1, ta, tb, wa, wb, wv, cy_r, c1, c2;
  logic signed [63:0] prod;
  logic signed [33:0] pa;
  logic signed [ACC_W-1:0] accx, accy;

  logic               div_start;
  logic signed [32:0] div_num, div_den;
  logic               div_done;
  logic signed [31:0] div_quo;

  logic [CNT_W-1:0]   i_x;
  logic [CNT_W-1:0]   lvl_last;
  logic [CNT_W-1:0]   sum_last;
  logic [CNT_W-1:0]   a_k1, a_k;
  logic               w0;
  logic signed [31:0] wnew;

  always_comb begin
    i_x      = CNT_W'(i);
    lvl_last = m_r - CNT_W'(k) - CNT_W'(1);
    sum_last = m_r - CNT_W'(kk_r) - CNT_W'(1);
    a_k1     = i_x + CNT_W'(k) - CNT_W'(1);
    a_k      = i_x + CNT_W'(k);
    k_raddr  = i;
    w_raddr  = i;
    case (state)
      S_Z_RD1, S_L_RD1: begin
        k_raddr = 5'(i_x + CNT_W'(1));
        w_raddr = 5'(i_x + CNT_W'(1));
      end
      S_L_RD2: k_raddr = a_k1[SLOT_W-1:0];
      S_L_RD3: k_raddr = a_k[SLOT_W-1:0];
      default: begin
        k_raddr = i;
      end
    endcase
    w0 = (u >= t0 && u < kq) || (last && i_x == m_r - CNT_W'(2));
    wnew = sat32(ACC_W'(pa) + ACC_W'(trunc_q30(prod)));
  end

  always_comb begin
    div_start = (state == S_L_RD4) || (state == S_L_DV1 && div_done);
    if (state == S_L_RD4) begin
      div_num = {u[31], u} - {t0[31], t0};
      div_den = {ta[31], ta} - {t0[31], t0};
    end else begin
      div_num = {tb[31], tb} - {u[31], u};
      div_den = {tb[31], tb} - {t1[31], t1};
    end
  end

  bspl_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Table memories: one write and registered reads.
  always_ff @(posedge clk) begin
    kq <= kmem[k_raddr];
    wq <= wmem[w_raddr];
    cq <= cmem[i];
    if (state == S_IDLE && in_valid && in_item.kind == KIND_KNOT) begin
      kmem[in_item.slot] <= in_item.knot_value;
    end
    if (state == S_IDLE && in_valid && in_item.kind == KIND_CTRL) begin
      cmem[in_item.slot] <= {in_item.ctrl_y, in_item.ctrl_x};
    end
    if (state == S_Z_WR) begin
      wmem[i] <= w0 ? ONE_Q30 : 32'sd0;
    end else if (state == S_L_MU3) begin
      wmem[i] <= wnew;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.curve_x = sat32(accx);
  assign res.curve_y = sat32(accy);
  assign res.ok      = okr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_item.kind == KIND_EVAL) begin
            m_r  <= cfg.m;
            kk_r <= cfg.kk;
            u    <= in_item.param_u;
            last <= in_item.last_param;
            i    <= '0;
            accx <= '0;
            accy <= '0;
            if (cfg.m <= CNT_W'(cfg.kk)) begin
              okr   <= 1'b0;
              state <= S_DONE;
            end else begin
              okr   <= 1'b1;
              state <= S_Z_RD0;
            end
          end
        end
        S_Z_RD0: state <= S_Z_RD1;
        S_Z_RD1: begin
          t0    <= kq;
          state <= S_Z_WR;
        end
        S_Z_WR: begin
          if (i_x == m_r - CNT_W'(2)) begin
            i <= '0;
            k <= ORD_W'(2);
            state <= (kk_r >= ORD_W'(2)) ? S_L_RD0 : S_S_RD;
          end else begin
            i     <= i + 1'b1;
            state <= S_Z_RD0;
          end
        end
        S_L_RD0: state <= S_L_RD1;
        S_L_RD1: begin
          t0    <= kq;
          wa    <= wq;
          state <= S_L_RD2;
        end
        S_L_RD2: begin
          t1    <= kq;
          wb    <= wq;
          state <= S_L_RD3;
        end
        S_L_RD3: begin
          ta    <= kq;
          state <= S_L_RD4;
        end
        S_L_RD4: begin
          tb    <= kq;
          state <= S_L_DV1;
        end
        S_L_DV1: begin
          if (div_done) begin
            c1    <= div_quo;
            state <= S_L_DV2;
          end
        end
        S_L_DV2: begin
          if (div_done) begin
            c2    <= div_quo;
            state <= S_L_MU1;
          end
        end
        S_L_MU1: begin
          prod  <= c1 * wa;
          state <= S_L_MU2;
        end
        S_L_MU2: begin
          pa    <= trunc_q30(prod);
          prod  <= c2 * wb;
          state <= S_L_MU3;
        end
        S_L_MU3: begin
          // weight written this cycle; advance over spans, then levels
          if (i_x == lvl_last) begin
            i <= '0;
            if (k == kk_r) begin
              state <= S_S_RD;
            end else begin
              k     <= k + 1'b1;
              state <= S_L_RD0;
            end
          end else begin
            i     <= i + 1'b1;
            state <= S_L_RD0;
          end
        end
        S_S_RD: state <= S_S_MX;
        S_S_MX: begin
          prod  <= wq * $signed(cq[31:0]);
          wv    <= wq;
          cy_r  <= $signed(cq[63:32]);
          state <= S_S_MY;
        end
        S_S_MY: begin
          accx  <= accx + ACC_W'(trunc_q30(prod));
          prod  <= wv * cy_r;
          state <= S_S_AY;
        end
        S_S_AY: begin
          accy <= accy + ACC_W'(trunc_q30(prod));
          if (i_x == sum_last) begin
            state <= S_DONE;
          end else begin
            i     <= i + 1'b1;
            state <= S_S_RD;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/bspline_curve_eval_top.sv]
// ----------------------------------------------------------------------------
// bspline_curve_eval_top
// B-spline curve point evaluator with knot and control-point tables.
// ----------------------------------------------------------------------------
// Load items (knot or control point) are written into the tables as they
// are accepted. An evaluate item runs a degree-0 pass over M-1 weights,
// then each higher level in turn, from M-2 weights at level 2 down to M-K
// at level K, where one shared divider computes the two ratios of each
// weight, and then a final sum over M-K weighted control points; M is the
// knot count in use and K the order. Items are taken one at a time; a
// finished result waits in an output register while the next item is
// accepted. Table entries must be written before they are used by an evaluation.
`default_nettype none

module bspline_curve_eval_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // slot[4:0], knot_value[36:5], ctrl_x[68:37], ctrl_y[100:69],
  // param_u[132:101], zero fill
  input  wire logic [135:0] s_axis_tdata,
  input  wire logic [1:0]   s_axis_tuser,   // kind
  input  wire logic         s_axis_tlast,   // last_param
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [63:0]       m_axis_tdata,   // curve_x[31:0], curve_y[63:32]
  output logic              m_axis_tuser,   // ok
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [5:0]   cfg_wdata
);
  import bspl_pkg::*;

  logic [1:0]  degree;
  logic [5:0]  knot_count;
  cfg_t        cfg;
  item_t       item;
  logic        res_valid;
  logic        res_ready;
  result_t     res;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree     <= 2'd3;
      knot_count <= 6'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEGREE:     degree     <= cfg_wdata[1:0];
        CFG_KNOT_COUNT: knot_count <= cfg_wdata;
        default: begin
          degree <= degree;
        end
      endcase
    end
  end

  always_comb begin
    cfg.m  = (knot_count > CNT_W'(MAX_KNOTS)) ? CNT_W'(MAX_KNOTS) : CNT_W'(knot_count);
    cfg.kk = ((degree > 2'(MAX_DEGREE)) ? ORD_W'(MAX_DEGREE) : ORD_W'(degree))
             + ORD_W'(1);
    item.kind       = kind_t'(s_axis_tuser);
    item.slot       = s_axis_tdata[4:0];
    item.knot_value = s_axis_tdata[36:5];
    item.ctrl_x     = s_axis_tdata[68:37];
    item.ctrl_y     = s_axis_tdata[100:69];
    item.param_u    = s_axis_tdata[132:101];
    item.last_param = s_axis_tlast;
  end

  bspl_eval u_eval (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_item   (item),
    .in_ready  (s_axis_tready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load when empty or being drained.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_axis_tdata <= {res.curve_y, res.curve_x};
      m_axis_tuser <= res.ok;
    end
  end

endmodule

`default_nettype wire
